// File: rtl/rtime_page_decompressor_defines.svh
// assertion macros shared by the page decompressor modules
`ifndef RTIME_PAGE_DECOMPRESSOR_DEFINES_SVH
`define RTIME_PAGE_DECOMPRESSOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/rpd_pkg.sv
// shared types and constants of the page decompressor
package rpd_pkg;

	localparam int MAX_PAGE_BYTES_DEF = 4096;
	localparam int PAGE_LEN_RESET     = 4096;

	typedef struct packed {
		logic [7:0]  literal;
		logic [7:0]  repeat_count;
		logic        page_start;
		logic [12:0] page_length;
	} pair_t;

	typedef struct packed {
		logic [63:0] packed_bytes;
		logic [3:0]  byte_count;
		logic        run_last;
		logic        page_full;
	} result_t;

	// one byte (or an empty close) handed to the packer
	typedef struct packed {
		logic       valid;
		logic       has_byte;
		logic [7:0] data;
		logic       last;
		logic       full;
	} push_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIT,
		ST_COPY
	} state_t;

endpackage

// File: rtl/rpd_chan_if.sv
// valid/ready channel carrying one payload of type T
interface rpd_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rpd_pos_table.sv
// last-position table: 256 entries, registered read, valid bits for page clear
module rpd_pos_table #(
	parameter int PW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [7:0]    rd_addr,
	input  logic          clear,
	input  logic          wr_en,
	input  logic [7:0]    wr_addr,
	input  logic [PW-1:0] wr_data,
	output logic [PW-1:0] rd_data
);

	logic [PW-1:0] mem [256];
	logic [255:0]  valid_q;
	logic [PW-1:0] rd_s1;
	logic          rd_valid_s1;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// valid bits, all cleared together at page start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= clear ? 1'b0 : valid_q[rd_addr];
			end
		end
	end

	// an entry not written on this page reads as zero
	assign rd_data = rd_valid_s1 ? rd_s1 : '0;

endmodule

// File: rtl/rpd_history.sv
// page history memory, one read and one write port, write-to-read forwarding
module rpd_history #(
	parameter int MAX_PAGE_BYTES = rpd_pkg::MAX_PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [$clog2(MAX_PAGE_BYTES)-1:0] rd_addr,
	input  logic                              wr_en,
	input  logic [$clog2(MAX_PAGE_BYTES)-1:0] wr_addr,
	input  logic [7:0]                        wr_data,
	output logic [7:0]                        rd_data
);

	logic [7:0]    mem [MAX_PAGE_BYTES];
	logic [7:0]    rd_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;

	// write, registered read, and capture of a colliding write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1       <= mem[rd_addr];
			fwd_s1      <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// a byte written in the read cycle wins over the old contents
	assign rd_data = fwd_s1 ? fwd_data_s1 : rd_s1;

endmodule

// File: rtl/rpd_packer.sv
// packs bytes into results of up to eight bytes and holds the result register
`include "rtime_page_decompressor_defines.svh"

module rpd_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rpd_pkg::push_t              push,
	output logic                        free,
	rpd_chan_if.source                  result
);

	logic [7:0][7:0]  acc_q;
	logic [3:0]       cnt_q;
	logic             done_q;
	logic             last_q;
	logic             full_q;
	logic             ov_q;
	rpd_pkg::result_t out_q;
	logic             move;
	logic [3:0]       base;
	logic [3:0]       cnt_next;
	logic [63:0]      masked;

	// word handoff into the result register
	assign move     = done_q && (!ov_q || result.ready);
	assign base     = move ? 4'd0 : cnt_q;
	assign cnt_next = base + {3'd0, push.has_byte};
	assign free     = !ov_q && !done_q;

	// unused high bytes read as zero
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			masked[j*8 +: 8] = (4'(j) < cnt_q) ? acc_q[j] : 8'd0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			if (move) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			if (push.valid) begin
				cnt_q  <= cnt_next;
				done_q <= push.last || (cnt_next == 4'd8);
			end else if (move) begin
				cnt_q  <= 4'd0;
				done_q <= 1'b0;
			end
		end
	end

	// byte lanes and result payload
	always_ff @(posedge clk) begin
		if (push.valid && push.has_byte) begin
			acc_q[base[2:0]] <= push.data;
		end
		if (push.valid) begin
			last_q <= push.last;
			full_q <= push.full;
		end
		if (move) begin
			out_q.packed_bytes <= masked;
			out_q.byte_count   <= cnt_q;
			out_q.run_last     <= last_q;
			out_q.page_full    <= full_q;
		end
	end

	assign result.valid = ov_q;
	assign result.data  = out_q;

	`RPD_ASSERT_SAME(a_no_overrun, push.valid && done_q, move, "byte pushed into a held word")
	`RPD_ASSERT_SAME(a_empty_only_full, ov_q && (out_q.byte_count == 4'd0), out_q.run_last && out_q.page_full, "empty result on a page with room")
	`RPD_ASSERT_NEXT(a_last_closes, push.valid && push.last, done_q, "last byte did not close the word")

endmodule

// File: rtl/rtime_page_decompressor.sv
// top level of the rtime page decompressor
//
// pair channel (sink): one compressed pair per request: literal, repeat
// count, page start flag and page length. result channel (source): up to
// eight output bytes per request, first byte in the low lane, with a byte
// count, a flag on the last result of the pair and a page-full flag.
// The history memory moves one byte per cycle through its single read
// port while the packer is free; no byte is fetched while a finished word
// is handed into the result register, nor while it sits there.
// A pair is taken only while the block is idle; its literal waits until
// the result register of the previous pair has been emptied.
// If the receiver stalls, no byte is fetched while the result register is
// full, so the copy holds and resumes when the result is taken.
// Reset: the position table valid bits are cleared at once (no sweep),
// the output position goes to zero and the page length to 4096, clamped
// to MAX_PAGE_BYTES. History contents stay undefined until written.
// A pair on a page that is already full yields one empty result.
`include "rtime_page_decompressor_defines.svh"

module rtime_page_decompressor #(
	parameter int MAX_PAGE_BYTES = rpd_pkg::MAX_PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rpd_chan_if.sink    pair,
	rpd_chan_if.source  result
);

	localparam int PW = $clog2(MAX_PAGE_BYTES + 1);
	localparam int AW = $clog2(MAX_PAGE_BYTES);
	localparam int CW = (PW > 13) ? PW : 13;
	localparam int LEN_RESET = (rpd_pkg::PAGE_LEN_RESET > MAX_PAGE_BYTES) ?
		MAX_PAGE_BYTES : rpd_pkg::PAGE_LEN_RESET;

	rpd_pkg::state_t state_q, state_d;
	rpd_pkg::push_t  push;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] len_q;
	logic [PW-1:0] src_q;
	logic [7:0]    rd_left_q;
	logic [7:0]    wr_left_q;
	logic          rd_pend_s1;
	logic [7:0]    lit_q;
	logic [7:0]    rep_q;

	logic          accept;
	logic          pk_free;
	logic          lit_full;
	logic          lit_go;
	logic          issue;
	logic          arrive;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] room;
	logic [7:0]    copy_n;
	logic [PW-1:0] len_start;
	logic [CW-1:0] plen_w;

	logic          tbl_rd_en;
	logic          tbl_clear;
	logic          tbl_wr_en;
	logic [PW-1:0] tbl_rd_data;
	logic          hist_rd_en;
	logic          hist_wr_en;
	logic [7:0]    hist_wr_data;
	logic [7:0]    hist_rd_data;

	// request handshake and step conditions
	assign accept   = pair.valid && pair.ready;
	assign lit_full = pos_q >= len_q;
	assign lit_go   = (state_q == rpd_pkg::ST_LIT) && pk_free;
	assign issue    = (state_q == rpd_pkg::ST_COPY) && (rd_left_q != 8'd0) && pk_free;
	assign arrive   = (state_q == rpd_pkg::ST_COPY) && rd_pend_s1;
	assign pos_inc  = pos_q + PW'(1);

	// bytes left to copy before the page ends
	assign room   = len_q - pos_inc;
	assign copy_n = (room < PW'(rep_q)) ? room[7:0] : rep_q;

	// page length latched at page start, saturated to the memory size
	assign plen_w    = CW'(pair.data.page_length);
	assign len_start = (plen_w > CW'(MAX_PAGE_BYTES)) ? PW'(MAX_PAGE_BYTES) : PW'(plen_w);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rpd_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rpd_pkg::ST_LIT;
				end
			end
			rpd_pkg::ST_LIT: begin
				if (lit_go) begin
					state_d = (lit_full || copy_n == 8'd0) ? rpd_pkg::ST_IDLE :
						rpd_pkg::ST_COPY;
				end
			end
			rpd_pkg::ST_COPY: begin
				if (arrive && wr_left_q == 8'd1) begin
					state_d = rpd_pkg::ST_IDLE;
				end
			end
			default: state_d = rpd_pkg::ST_IDLE;
		endcase
	end

	// outputs to the memories and the packer
	always_comb begin
		pair.ready    = (state_q == rpd_pkg::ST_IDLE);
		tbl_rd_en     = accept;
		tbl_clear     = accept && pair.data.page_start;
		tbl_wr_en     = lit_go && !lit_full;
		hist_rd_en    = issue;
		hist_wr_en    = (lit_go && !lit_full) || arrive;
		hist_wr_data  = arrive ? hist_rd_data : lit_q;
		push          = '0;
		if (lit_go) begin
			push.valid    = 1'b1;
			push.has_byte = !lit_full;
			push.data     = lit_q;
			push.last     = lit_full || (copy_n == 8'd0);
			push.full     = lit_full || (pos_inc >= len_q);
		end else if (arrive) begin
			push.valid    = 1'b1;
			push.has_byte = 1'b1;
			push.data     = hist_rd_data;
			push.last     = (wr_left_q == 8'd1);
			push.full     = pos_inc >= len_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rpd_pkg::ST_IDLE;
			pos_q      <= '0;
			len_q      <= PW'(LEN_RESET);
			rd_left_q  <= 8'd0;
			wr_left_q  <= 8'd0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= issue;
			if (accept && pair.data.page_start) begin
				pos_q <= '0;
				len_q <= len_start;
			end
			if (lit_go && !lit_full) begin
				pos_q     <= pos_inc;
				rd_left_q <= copy_n;
				wr_left_q <= copy_n;
			end
			if (issue) begin
				rd_left_q <= rd_left_q - 8'd1;
			end
			if (arrive) begin
				pos_q     <= pos_inc;
				wr_left_q <= wr_left_q - 8'd1;
			end
		end
	end

	// pair fields and copy source pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			lit_q <= pair.data.literal;
			rep_q <= pair.data.repeat_count;
		end
		if (lit_go) begin
			src_q <= tbl_rd_data;
		end else if (issue) begin
			src_q <= src_q + PW'(1);
		end
	end

	rpd_pos_table #(
		.PW (PW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (tbl_rd_en),
		.rd_addr (pair.data.literal),
		.clear   (tbl_clear),
		.wr_en   (tbl_wr_en),
		.wr_addr (lit_q),
		.wr_data (pos_inc),
		.rd_data (tbl_rd_data)
	);

	rpd_history #(
		.MAX_PAGE_BYTES (MAX_PAGE_BYTES)
	) u_history (
		.clk     (clk),
		.rd_en   (hist_rd_en),
		.rd_addr (src_q[AW-1:0]),
		.wr_en   (hist_wr_en),
		.wr_addr (pos_q[AW-1:0]),
		.wr_data (hist_wr_data),
		.rd_data (hist_rd_data)
	);

	rpd_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.free   (pk_free),
		.result (result)
	);

	`RPD_ASSERT_SAME(a_pos_in_page, 1'b1, pos_q <= len_q, "output position past page length")
	`RPD_ASSERT_SAME(a_read_behind, hist_rd_en, src_q <= pos_q, "history read ahead of output")
	`RPD_ASSERT_SAME(a_pend_counted, arrive, wr_left_q != 8'd0, "history byte with no copy left")

endmodule
